@@ hdl/assert_macros.svh @@
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/bsds_pkg.sv @@
`default_nettype none
package bsds_pkg;
    localparam int ROW_WIDTH_DEF = 1024;
    localparam int MAX_DISP_DEF  = 128;
    localparam int COL_W   = 10;
    localparam int COLOR_W = 24;
    localparam int DATA_W  = 32;
    localparam int COST_W  = 18;
    localparam int QDEPTH  = 2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic               kind;
        logic               in_range;
        logic [COL_W-1:0]   column;
        logic [COLOR_W-1:0] color;
        logic [DATA_W-1:0]  near_depth;
        logic [DATA_W-1:0]  far_depth;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] depth_value;
        logic [COST_W-1:0] best_cost;
        logic              found;
    } res_t;
endpackage
`default_nettype wire

@@ hdl/bounded_stereo_disparity_search_unit.sv @@
// Write word: stored in the row store by the back end after the queue.
// Query: start-bound division (none when near_depth is 0), then per tried
// disparity a row store read and then a cost step, then depth division (only
// when a disparity was found) and an output step; one query at a time.
// Reset (async, active low) empties both queues and clears focal_baseline;
// the row store is not cleared.
`default_nettype none
module bounded_stereo_disparity_search_unit #(
    parameter int ROW_WIDTH     = bsds_pkg::ROW_WIDTH_DEF,
    parameter int MAX_DISPARITY = bsds_pkg::MAX_DISP_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [bsds_pkg::DATA_W-1:0]   cfg_wdata,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          kind,
    input  wire logic [bsds_pkg::COL_W-1:0]    column,
    input  wire logic [bsds_pkg::COLOR_W-1:0]  pixel_color,
    input  wire logic [bsds_pkg::DATA_W-1:0]   near_depth,
    input  wire logic [bsds_pkg::DATA_W-1:0]   far_depth,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [bsds_pkg::DATA_W-1:0]        depth_value,
    output logic [bsds_pkg::COST_W-1:0]        best_cost,
    output logic                               found
);
    logic [bsds_pkg::DATA_W-1:0] fb_reg;
    bsds_pkg::cmd_t              fq_wdata, fq_rdata;
    logic                        fq_push, fq_full, fq_pop, fq_empty;
    bsds_pkg::res_t              oq_wdata, oq_rdata;
    logic                        oq_push, oq_full;
    logic                        div_start, div_done;
    logic [bsds_pkg::DATA_W-1:0] div_num, div_den, div_quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_reg <= '0;
        end
        else if (cfg_we)
        begin
            fb_reg <= cfg_wdata;
        end
    end

    bsds_front #(.ROW_WIDTH(ROW_WIDTH)) u_front (
        .push(push), .full(full), .kind(kind), .column(column),
        .pixel_color(pixel_color), .near_depth(near_depth), .far_depth(far_depth),
        .q_push(fq_push), .q_data(fq_wdata), .q_full(fq_full)
    );

    bsds_fifo #(.T(bsds_pkg::cmd_t)) u_cmd_q (
        .clk(clk), .rst_n(rst_n), .push(fq_push), .wdata(fq_wdata), .full(fq_full),
        .pop(fq_pop), .rdata(fq_rdata), .empty(fq_empty)
    );

    bsds_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
        .done(div_done), .quot(div_quot)
    );

    bsds_back #(.ROW_WIDTH(ROW_WIDTH), .MAX_DISPARITY(MAX_DISPARITY)) u_back (
        .clk(clk), .rst_n(rst_n), .fb(fb_reg), .q_data(fq_rdata), .q_empty(fq_empty),
        .q_pop(fq_pop), .div_start(div_start), .div_num(div_num), .div_den(div_den),
        .div_done(div_done), .div_quot(div_quot), .o_push(oq_push), .o_data(oq_wdata),
        .o_full(oq_full)
    );

    bsds_fifo #(.T(bsds_pkg::res_t)) u_res_q (
        .clk(clk), .rst_n(rst_n), .push(oq_push), .wdata(oq_wdata), .full(oq_full),
        .pop(pop), .rdata(oq_rdata), .empty(empty)
    );

    assign depth_value = oq_rdata.depth_value;
    assign best_cost   = oq_rdata.best_cost;
    assign found       = oq_rdata.found;
endmodule
`default_nettype wire

@@ hdl/bsds_fifo.sv @@
`default_nettype none
module bsds_fifo #(
    parameter type T = logic
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire T     wdata,
    output logic      full,
    input  wire logic pop,
    output T          rdata,
    output logic      empty
);
    localparam int PW = $clog2(bsds_pkg::QDEPTH);
    T               mem_reg [bsds_pkg::QDEPTH];
    logic [PW-1:0]  wp_reg, rp_reg;
    logic [PW:0]    cnt_reg;
    logic           do_push, do_pop;

    assign full    = (cnt_reg == (PW+1)'(bsds_pkg::QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (do_pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

@@ hdl/bsds_front.sv @@
`default_nettype none
module bsds_front #(
    parameter int ROW_WIDTH = bsds_pkg::ROW_WIDTH_DEF
) (
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          kind,
    input  wire logic [bsds_pkg::COL_W-1:0]    column,
    input  wire logic [bsds_pkg::COLOR_W-1:0]  pixel_color,
    input  wire logic [bsds_pkg::DATA_W-1:0]   near_depth,
    input  wire logic [bsds_pkg::DATA_W-1:0]   far_depth,
    output logic                               q_push,
    output bsds_pkg::cmd_t                     q_data,
    input  wire logic                          q_full
);
    assign full   = q_full;
    assign q_push = push;

    always_comb
    begin
        q_data            = '0;
        q_data.kind       = kind;
        q_data.in_range   = (32'(column) < 32'(ROW_WIDTH));
        q_data.column     = column;
        q_data.color      = pixel_color;
        q_data.near_depth = near_depth;
        q_data.far_depth  = far_depth;
    end
endmodule
`default_nettype wire

@@ hdl/bsds_div.sv @@
`default_nettype none
module bsds_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [bsds_pkg::DATA_W-1:0] num,
    input  wire logic [bsds_pkg::DATA_W-1:0] den,
    output logic                             done,
    output logic [bsds_pkg::DATA_W-1:0]      quot
);
    localparam int W  = bsds_pkg::DATA_W;
    localparam int CW = $clog2(W + 1);
    logic [W:0]    rem_reg;
    logic [W-1:0]  q_reg, den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [W:0]    trial;
    logic          ge;

    assign trial = {rem_reg[W-1:0], q_reg[W-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign done  = done_reg;
    assign quot  = q_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (trial - {1'b0, den_reg}) : trial;
            q_reg   <= {q_reg[W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ hdl/bsds_back.sv @@
`default_nettype none
module bsds_back #(
    parameter int ROW_WIDTH     = bsds_pkg::ROW_WIDTH_DEF,
    parameter int MAX_DISPARITY = bsds_pkg::MAX_DISP_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [bsds_pkg::DATA_W-1:0] fb,
    input  wire bsds_pkg::cmd_t              q_data,
    input  wire logic                        q_empty,
    output logic                             q_pop,
    output logic                             div_start,
    output logic [bsds_pkg::DATA_W-1:0]      div_num,
    output logic [bsds_pkg::DATA_W-1:0]      div_den,
    input  wire logic                        div_done,
    input  wire logic [bsds_pkg::DATA_W-1:0] div_quot,
    output logic                             o_push,
    output bsds_pkg::res_t                   o_data,
    input  wire logic                        o_full
);
    localparam int AW = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
    localparam int IW = (AW > bsds_pkg::COL_W) ? AW : bsds_pkg::COL_W;
    localparam int DW = $clog2(MAX_DISPARITY + 1);
    localparam int W  = bsds_pkg::DATA_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIVS  = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_EV    = 3'd3;
    localparam logic [2:0] ST_DIVD  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [bsds_pkg::COLOR_W-1:0] mem [ROW_WIDTH];
    logic [bsds_pkg::COLOR_W-1:0] rdata_reg;

    logic [2:0]                   st_reg;
    logic [DW-1:0]                d_reg, best_d_reg;
    logic [bsds_pkg::COL_W-1:0]   col_reg;
    logic [bsds_pkg::COLOR_W-1:0] color_reg;
    logic [W-1:0]                 far_reg, depth_reg;
    logic [W+DW-1:0]              prod_reg;
    logic [bsds_pkg::COST_W-1:0]  cost_reg;
    logic                         found_reg;

    logic [IW-1:0]                wcol, rcol;
    logic                         mem_we, mem_re;
    logic [W-1:0]                 lim_a, lim_b;
    logic [W-1:0]                 min_src;
    logic [7:0]                   dr, dg, db;
    logic [bsds_pkg::COST_W-1:0]  cost;

    function automatic logic [7:0] absd(input logic [7:0] a, input logic [7:0] b);
        absd = (a > b) ? (a - b) : (b - a);
    endfunction

    assign wcol   = IW'(q_data.column);
    assign rcol   = IW'(col_reg) - IW'(d_reg);
    assign mem_we = (st_reg == ST_IDLE) && !q_empty && (q_data.kind == bsds_pkg::KIND_WRITE)
                    && q_data.in_range;
    assign mem_re = (st_reg == ST_RD);
    assign q_pop  = (st_reg == ST_IDLE) && !q_empty;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wcol[AW-1:0]] <= q_data.color;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[rcol[AW-1:0]];
        end
    end

    assign min_src = (st_reg == ST_IDLE) ? '1 : div_quot;
    always_comb
    begin
        lim_a = (min_src > W'(MAX_DISPARITY)) ? W'(MAX_DISPARITY) : min_src;
        lim_b = (lim_a > W'(col_reg)) ? W'(col_reg) : lim_a;
    end

    assign dr   = absd(color_reg[23:16], rdata_reg[23:16]);
    assign dg   = absd(color_reg[15:8],  rdata_reg[15:8]);
    assign db   = absd(color_reg[7:0],   rdata_reg[7:0]);
    assign cost = bsds_pkg::COST_W'(dr) * bsds_pkg::COST_W'(dr)
                  + bsds_pkg::COST_W'(dg) * bsds_pkg::COST_W'(dg)
                  + bsds_pkg::COST_W'(db) * bsds_pkg::COST_W'(db);

    always_comb
    begin
        div_start = 1'b0;
        div_num   = fb;
        div_den   = q_data.near_depth;
        if (st_reg == ST_IDLE && !q_empty && q_data.kind == bsds_pkg::KIND_QUERY
            && q_data.in_range && q_data.near_depth != '0)
        begin
            div_start = 1'b1;
        end
        else if ((st_reg == ST_RD && d_reg == '0 && found_reg)
                 || (st_reg == ST_EV && !(W'(0) + {{DW{1'b0}}, fb} < prod_reg) && found_reg))
        begin
            div_start = 1'b1;
            div_den   = W'(best_d_reg);
        end
    end

    assign o_push = (st_reg == ST_OUT) && !o_full;
    always_comb
    begin
        o_data             = '0;
        o_data.depth_value = depth_reg;
        o_data.best_cost   = cost_reg;
        o_data.found       = found_reg;
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            ST_IDLE:
            begin
                col_reg    <= q_data.column;
                color_reg  <= q_data.color;
                far_reg    <= q_data.far_depth;
                cost_reg   <= '0;
                depth_reg  <= '0;
                best_d_reg <= '0;
                d_reg      <= DW'(lim_b);
                if (q_data.near_depth == '0)
                begin
                    d_reg <= (32'(q_data.column) < 32'(MAX_DISPARITY)) ?
                             DW'(q_data.column) : DW'(MAX_DISPARITY);
                end
            end
            ST_DIVS:
            begin
                d_reg <= DW'(lim_b);
            end
            ST_RD:
            begin
                prod_reg <= far_reg * d_reg;
            end
            ST_EV:
            begin
                if ({{DW{1'b0}}, fb} < prod_reg)
                begin
                    if (!found_reg || cost < cost_reg)
                    begin
                        cost_reg   <= cost;
                        best_d_reg <= d_reg;
                    end
                    d_reg <= d_reg - 1'b1;
                end
            end
            ST_DIVD:
            begin
                depth_reg <= div_quot;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            found_reg <= 1'b0;
        end
        else
        begin
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (!q_empty && q_data.kind == bsds_pkg::KIND_QUERY)
                    begin
                        found_reg <= 1'b0;
                        if (!q_data.in_range)
                        begin
                            st_reg <= ST_OUT;
                        end
                        else if (q_data.near_depth == '0)
                        begin
                            st_reg <= ST_RD;
                        end
                        else
                        begin
                            st_reg <= ST_DIVS;
                        end
                    end
                end
                ST_DIVS:
                begin
                    if (div_done)
                    begin
                        st_reg <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    if (d_reg == '0)
                    begin
                        st_reg <= found_reg ? ST_DIVD : ST_OUT;
                    end
                    else
                    begin
                        st_reg <= ST_EV;
                    end
                end
                ST_EV:
                begin
                    if ({{DW{1'b0}}, fb} < prod_reg)
                    begin
                        found_reg <= 1'b1;
                        st_reg    <= ST_RD;
                    end
                    else
                    begin
                        st_reg <= found_reg ? ST_DIVD : ST_OUT;
                    end
                end
                ST_DIVD:
                begin
                    if (div_done)
                    begin
                        st_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!o_full)
                    begin
                        st_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hdl/bsds_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module bsds_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         empty,
    input wire logic                         pop,
    input wire logic [bsds_pkg::DATA_W-1:0]  depth_value,
    input wire logic [bsds_pkg::COST_W-1:0]  best_cost,
    input wire logic                         found
);
    `ASSERT_ALWAYS(a_nf_zero, clk, rst_n, empty || found || (depth_value == '0 && best_cost == '0))
    `ASSERT_ALWAYS(a_cost_max, clk, rst_n, empty || best_cost <= 18'd195075)
    `ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(depth_value))
endmodule

bind bounded_stereo_disparity_search_unit bsds_checker u_chk (.*);
`default_nettype wire
